FILE: src/msss_pkg.sv
// ----------------------------------------------------------------------------
// msss_pkg: shared types and constants for the masked byte signature scan
// holds register indexes, field widths and the configuration bundle
// ----------------------------------------------------------------------------
`default_nettype none

package msss_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int PLEN_W    = 6;
  localparam int MASK_W    = 32;
  localparam int SIG_BYTES = 32;
  localparam int SIG_W     = SIG_BYTES * 8;
  localparam int ADDR_W    = 64;
  localparam int CFG_DW    = 64;
  localparam int CFG_IW    = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_PATTERN_LEN   = 3'd0,
    REG_MATCH_MASK    = 3'd1,
    REG_PATTERN_WORD0 = 3'd2,
    REG_PATTERN_WORD1 = 3'd3,
    REG_PATTERN_WORD2 = 3'd4,
    REG_PATTERN_WORD3 = 3'd5
  } reg_idx_t;

  // configuration seen by every cell
  typedef struct packed {
    logic [PLEN_W-1:0] pattern_len;
    logic [MASK_W-1:0] match_mask;
    logic [SIG_W-1:0]  pattern;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/masked_byte_signature_scan_unit.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_unit: wildcard byte pattern search
// scans a buffer byte by byte and reports the first signature match address
// ----------------------------------------------------------------------------
// throughput: one byte word per cycle while in_stall is low, set by the shift of the cell row and
//   the combinational masked compare over all cells
// result: the result word is registered and valid in the cycle after the last byte is taken
// input keeps flowing while a result waits, unless that result is stalled
// reset (rst_n low, synchronous) clears registers, count, hit and output valid
`default_nettype none

module masked_byte_signature_scan_unit #(
  parameter int MAX_PATTERN = msss_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = msss_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_wr_en,
  input  wire logic [msss_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [msss_pkg::CFG_DW-1:0]   cfg_wdata,
  // byte stream
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic [msss_pkg::ADDR_W-1:0]   in_buffer_base,
  input  wire logic                          in_last_byte,
  // result
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [msss_pkg::ADDR_W-1:0]        out_match_address
);

  localparam int ADDR_W = msss_pkg::ADDR_W;

  // configuration registers
  logic [msss_pkg::PLEN_W-1:0] pattern_len_r;
  logic [msss_pkg::MASK_W-1:0] match_mask_r;
  logic [msss_pkg::SIG_W-1:0]  pattern_r;
  msss_pkg::cfg_t              cfg;

  // scan state
  logic [COUNT_BITS-1:0] count_r;
  logic [ADDR_W-1:0]     base_latch_r;
  logic                  hit_r;
  logic [ADDR_W-1:0]     hit_addr_r;

  // output register
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [ADDR_W-1:0]     out_addr_r;

  logic                  in_accept;
  logic                  out_accept;
  logic [7:0]            cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;
  logic                  win_match;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  plen_ok;
  logic                  len_reached;
  logic                  new_hit;
  logic [ADDR_W-1:0]     base_sel;
  logic [COUNT_BITS-1:0] offset;
  logic [ADDR_W-1:0]     addr_nxt;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r <= '0;
      match_mask_r  <= '0;
      pattern_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        msss_pkg::REG_PATTERN_LEN:   pattern_len_r <= cfg_wdata[msss_pkg::PLEN_W-1:0];
        msss_pkg::REG_MATCH_MASK:    match_mask_r  <= cfg_wdata[msss_pkg::MASK_W-1:0];
        msss_pkg::REG_PATTERN_WORD0: pattern_r[63:0]    <= cfg_wdata;
        msss_pkg::REG_PATTERN_WORD1: pattern_r[127:64]  <= cfg_wdata;
        msss_pkg::REG_PATTERN_WORD2: pattern_r[191:128] <= cfg_wdata;
        msss_pkg::REG_PATTERN_WORD3: pattern_r[255:192] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.pattern_len = pattern_len_r;
  assign cfg.match_mask  = match_mask_r;
  assign cfg.pattern     = pattern_r;

  // ---------------- handshake ----------------
  // input only waits when a finished result is held by the consumer
  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  // ---------------- cell row ----------------
  // cell 0 takes the newest byte, each cell passes its byte down the row
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] feed;
    if (i == 0) begin : g_head
      assign feed = in_data_byte;
    end else begin : g_body
      assign feed = cell_byte[i-1];
    end
    msss_cell #(.POS(i)) u_cell (
      .clk      (clk),
      .shift_en (in_accept),
      .byte_in  (feed),
      .cfg      (cfg),
      .byte_out (cell_byte[i]),
      .match_ok (cell_ok[i])
    );
  end

  // wildcards and unused cells report ok, so the whole row must agree
  assign win_match = &cell_ok;

  // ---------------- match tracking ----------------
  // saturating byte count
  assign count_inc   = (count_r == {COUNT_BITS{1'b1}}) ? count_r : count_r + 1'b1;
  assign plen_ok     = (pattern_len_r != '0) &&
                       (7'(pattern_len_r) <= 7'(MAX_PATTERN));
  assign len_reached = count_inc >= COUNT_BITS'(pattern_len_r);
  assign new_hit     = !hit_r && plen_ok && len_reached && win_match;

  // base is sampled on the first byte of a buffer
  assign base_sel = (count_r == '0) ? in_buffer_base : base_latch_r;
  assign offset   = count_inc - COUNT_BITS'(pattern_len_r);
  assign addr_nxt = base_sel + ADDR_W'(offset);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      base_latch_r <= '0;
      hit_r        <= 1'b0;
      hit_addr_r   <= '0;
    end else if (in_accept) begin
      base_latch_r <= base_sel;
      if (in_last_byte) begin
        // end of buffer clears the per-buffer state
        count_r    <= '0;
        hit_r      <= 1'b0;
        hit_addr_r <= '0;
      end else begin
        count_r <= count_inc;
        if (new_hit) begin
          hit_r      <= 1'b1;
          hit_addr_r <= addr_nxt;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_last_byte) begin
      out_found_r <= hit_r || new_hit;
      if (hit_r) begin
        out_addr_r <= hit_addr_r;
      end else if (new_hit) begin
        out_addr_r <= addr_nxt;
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

`default_nettype wire

FILE: src/msss_cell.sv
// ----------------------------------------------------------------------------
// msss_cell: one window byte of the signature scan
// holds a byte, passes it to the next cell and checks the byte entering it
// against its signature byte
// ----------------------------------------------------------------------------
`default_nettype none

module msss_cell #(
  parameter int POS = 0
) (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire logic [7:0]    byte_in,
  input  wire msss_pkg::cfg_t cfg,
  output logic [7:0]         byte_out,
  output logic               match_ok
);

  logic [7:0] byte_r;
  logic [4:0] rel;
  logic       care;
  logic [7:0] expected;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // this cell holds signature byte pattern_len-1-POS once shifted
  assign rel      = 5'(cfg.pattern_len - msss_pkg::PLEN_W'(POS + 1));
  assign care     = (msss_pkg::PLEN_W'(POS) < cfg.pattern_len) && cfg.match_mask[rel];
  assign expected = cfg.pattern[{rel, 3'b000} +: 8];

  // compare against the byte entering this cell
  assign match_ok = !care || (byte_in == expected);

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the masked byte signature scan unit
// streams byte words through the scanner under random idling and back
// pressure, predicts every found flag and match address with a local model of
// the window, count and hit latch, and compares each result word in order
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NWIN        = msss_pkg::MAX_PATTERN_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic [63:0] in_buffer_base = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [63:0] out_match_address;

  // local copy of the registers
  logic [5:0]   sig_len = '0;
  logic [31:0]  sig_mask = '0;
  logic [255:0] sig_pattern = '0;

  // local copy of the scan state
  logic [7:0]  win [NWIN];
  logic [31:0] bytes_seen = '0;
  logic [63:0] base_seen = '0;
  logic        hit_seen = 1'b0;
  logic [63:0] hit_addr = '0;

  scan_result_t pending_reports[$];
  logic [7:0]   buf_q[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  masked_byte_signature_scan_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_buffer_base    (in_buffer_base),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NWIN; i++) win[i] = 8'h00;
  end

  // receiver: a long hold-off wins over random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // one accepted byte word through the window, count and hit latch
  task automatic advance_scan(input logic [7:0] data, input logic [63:0] base,
                              input logic last);
    scan_result_t res;
    bit           hit;
    int           plen;
    if (bytes_seen == 0) base_seen = base;
    for (int j = NWIN - 1; j > 0; j--) win[j] = win[j-1];
    win[0] = data;
    if (bytes_seen != '1) bytes_seen++;
    plen = sig_len;
    // lengths above the window never match, and the count keeps matches
    // from reaching back into the previous buffer
    if (!hit_seen && plen >= 1 && plen <= NWIN && bytes_seen >= plen) begin
      hit = 1'b1;
      for (int j = 0; j < plen; j++)
        if (sig_mask[j] && win[plen-1-j] != sig_pattern[8*j +: 8]) hit = 1'b0;
      if (hit) begin
        hit_seen = 1'b1;
        hit_addr = base_seen + ({32'b0, bytes_seen} - 64'(plen));
      end
    end
    if (last) begin
      res.found = hit_seen;
      res.addr  = hit_seen ? hit_addr : 64'h0;
      pending_reports = {pending_reports, res};
      bytes_seen = '0;
      hit_seen   = 1'b0;
      hit_addr   = '0;
    end
  endtask

  // result check first, then the byte taken at this edge, then the watchdog
  always @(posedge clk) begin
    scan_result_t want;
    bit           busy;
    if (rst_n) begin
      busy = cfg_wr_en;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected result", {63'b0, out_found}, 64'h0);
        end else begin
          want = pending_reports.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", {63'b0, out_found}, {63'b0, want.found});
          if (out_match_address !== want.addr)
            report_mismatch("match_address", out_match_address, want.addr);
        end
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        advance_scan(in_data_byte, in_buffer_base, in_last_byte);
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // all driver tasks start and end on a falling edge
  task automatic cfg_write(input msss_pkg::reg_idx_t idx, input logic [63:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      msss_pkg::REG_PATTERN_LEN:   sig_len = val[5:0];
      msss_pkg::REG_MATCH_MASK:    sig_mask = val[31:0];
      msss_pkg::REG_PATTERN_WORD0: sig_pattern[63:0] = val;
      msss_pkg::REG_PATTERN_WORD1: sig_pattern[127:64] = val;
      msss_pkg::REG_PATTERN_WORD2: sig_pattern[191:128] = val;
      msss_pkg::REG_PATTERN_WORD3: sig_pattern[255:192] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_signature(input logic [5:0] plen, input logic [31:0] mask,
                               input logic [255:0] pat);
    cfg_write(msss_pkg::REG_PATTERN_LEN, {58'b0, plen});
    cfg_write(msss_pkg::REG_MATCH_MASK, {32'b0, mask});
    cfg_write(msss_pkg::REG_PATTERN_WORD0, pat[63:0]);
    cfg_write(msss_pkg::REG_PATTERN_WORD1, pat[127:64]);
    cfg_write(msss_pkg::REG_PATTERN_WORD2, pat[191:128]);
    cfg_write(msss_pkg::REG_PATTERN_WORD3, pat[255:192]);
  endtask

  // valid stays high from one word to the next unless the sender idles
  task automatic send_byte(input logic [7:0] data, input logic [63:0] base,
                           input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_byte   = data;
    in_buffer_base = base;
    in_last_byte   = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // base only matters on the first word, so the rest carry noise
  task automatic send_buf(input logic [63:0] base);
    for (int i = 0; i < buf_q.size(); i++)
      send_byte(buf_q[i], (i == 0) ? base : {$urandom, $urandom},
                i == buf_q.size() - 1);
  endtask

  // stop sending until every result is back, plus the output stage latency
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_zero_length();
    // registers still at reset: length zero never matches
    buf_q = '{8'h00, 8'h00};
    send_buf(64'h0);
  endtask

  task automatic test_exact_and_later_match();
    // first hit at offset 1 wins over the one at offset 3
    wait_idle();
    set_signature(6'd2, 32'h0000_0003, {240'b0, 8'hFF, 8'h00});
    buf_q = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_buf(64'h0000_1000_0000_0000);
  endtask

  task automatic test_wildcard_and_short();
    // middle byte is a wildcard, mask bits above the length are ignored
    wait_idle();
    set_signature(6'd3, 32'hFFFF_FFFD, {232'b0, 8'h33, 8'h22, 8'h11});
    buf_q = '{8'h11, 8'h99, 8'h33};
    send_buf(64'h0000_0000_0000_4000);
    // buffer shorter than the pattern
    buf_q = '{8'h11, 8'h22};
    send_buf(64'h0000_0000_0000_5000);
  endtask

  task automatic test_address_wrap();
    wait_idle();
    set_signature(6'd1, 32'h0000_0001, {248'b0, 8'hAB});
    // base plus offset wraps to zero and is still reported as found
    buf_q = '{8'h00, 8'h00, 8'hAB};
    send_buf(64'hFFFF_FFFF_FFFF_FFFE);
    // one-word buffer at the top of the address space
    buf_q = '{8'hAB};
    send_buf(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_no_cross_buffer();
    wait_idle();
    set_signature(6'd2, 32'h0000_0003, {240'b0, 8'hA5, 8'h5A});
    buf_q = '{8'h5A};
    send_buf(64'h100);
    buf_q = '{8'hA5};
    send_buf(64'h200);
  endtask

  task automatic test_length_too_large();
    wait_idle();
    set_signature(6'd63, 32'h0, '0);
    buf_q = '{8'h01, 8'h02};
    send_buf(64'h300);
  endtask

  task automatic test_config_mid_buffer();
    wait_idle();
    set_signature(6'd2, 32'h0000_0003, {240'b0, 8'h02, 8'h01});
    send_byte(8'h01, 64'h0000_0000_0000_8000, 1'b0);
    // no result pending here, so the wait only covers the pipeline
    wait_idle();
    cfg_write(msss_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0000_0701);
    send_byte(8'h07, {$urandom, $urandom}, 1'b1);
  endtask

  // one register setting, then buffers until about n_words have gone in
  task automatic run_random_block(input int n_words);
    logic [255:0] pat;
    logic [31:0]  mask;
    logic [5:0]   plen;
    int           kind, sent, blen, pos, span;
    for (int i = 0; i < 8; i++) pat[32*i +: 32] = $urandom;
    for (int i = 0; i < 32; i++) mask[i] = ($urandom_range(3) != 0);
    plen = 6'($urandom_range(6, 1));
    kind = $urandom_range(9);
    case (kind)
      0: plen = 6'd0;
      1: begin
        plen = 6'd32;
        mask = '1;
      end
      2: plen = 6'($urandom_range(63, 33));
      3: begin
        plen = 6'($urandom_range(8, 1));
        mask = '0;
      end
      4: begin
        plen = 6'($urandom_range(8, 1));
        pat  = '1;
      end
      5: plen = 6'($urandom_range(31, 16));
      default: ;
    endcase
    wait_idle();
    set_signature(plen, mask, pat);
    span = (plen > NWIN) ? NWIN : plen;
    sent = 0;
    while (sent < n_words) begin
      if (span >= 16) blen = $urandom_range(span + 8, span - 2);
      else blen = $urandom_range(span + 12, 1);
      buf_q.delete();
      for (int i = 0; i < blen; i++) buf_q = {buf_q, 8'($urandom_range(255))};
      // most buffers carry the signature somewhere, wildcards keep noise
      if (span > 0 && blen >= span && $urandom_range(9) < 7) begin
        pos = $urandom_range(blen - span, 0);
        for (int j = 0; j < span; j++)
          if (mask[j]) buf_q[pos+j] = pat[8*j +: 8];
      end
      send_buf({$urandom, $urandom});
      sent += blen;
    end
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int k = 0; k < 3; k++) run_random_block(32);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_signature(6'd1, 32'h0000_0001, {248'b0, 8'h3C});
    // receiver holds off while one-word buffers keep coming
    @(posedge clk);
    hold_left = 80;
    @(negedge clk);
    for (int i = 0; i < 30; i++) begin
      buf_q = '{($urandom_range(1) != 0) ? 8'h3C : 8'($urandom_range(255))};
      send_buf({$urandom, $urandom});
    end
    // sender pauses until every result is back, then resumes
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      buf_q = '{8'h3C, 8'($urandom_range(255))};
      send_buf({$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    snd_idle_pct = 19;
    rcv_idle_pct = 45;
    test_zero_length();
    test_exact_and_later_match();
    test_wildcard_and_short();
    test_address_wrap();
    test_no_cross_buffer();
    test_length_too_large();
    test_config_mid_buffer();

    test_random_traffic(19, 45);
    test_random_traffic(45, 19);
    test_random_traffic(0, 0);
    test_backpressure();

    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch("results left over", 64'(pending_reports.size()), 64'h0);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: masked_byte_signature_scan_unit.f
src/msss_pkg.sv
src/msss_cell.sv
src/masked_byte_signature_scan_unit.sv
test/tb_top.sv
